// ===== rtl/cid_pkg.sv =====
package cid_pkg;

  localparam int MAX_SIZE_DEF = 8;
  localparam int DATA_W       = 32;
  localparam int IDX_W        = 3;
  localparam int SIZE_W       = 4;
  localparam int PADDR_W      = 3;
  localparam int S_TDATA_W    = 40;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  // word index taken from paddr[2]
  typedef enum logic [0:0] {
    REG_MATRIX_SIZE = 1'b0
  } cid_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_CELL,
    ST_DRAIN,
    ST_CLOSE,
    ST_CDRAIN
  } cid_state_e;

  typedef enum logic [1:0] {
    WS_ZERO,
    WS_START,
    WS_ACC
  } cid_wsel_e;

  typedef struct packed {
    logic valid;
    logic sub;
    logic clr;
  } cid_issue_t;

endpackage

// ===== rtl/cid_ram.sv =====
module cid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/cid_mac.sv =====
module cid_mac import cid_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cid_issue_t        issue_i,
  input  logic [DATA_W-1:0] a_i,
  input  logic [DATA_W-1:0] b_i,
  output logic [DATA_W-1:0] acc_o,
  output logic              busy_o
);

  logic              v1_q, s1_q;
  logic              pv_q, ps_q;
  logic [DATA_W-1:0] prod_q, prod_d;
  logic [DATA_W-1:0] acc_q, acc_d;

  // low word of the product only: arithmetic wraps modulo 2^32
  assign prod_d = a_i * b_i;

  always_comb begin
    acc_d = acc_q;
    if (issue_i.clr) begin
      acc_d = '0;
    end else if (pv_q) begin
      acc_d = ps_q ? (acc_q - prod_q) : (acc_q + prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      s1_q  <= 1'b0;
      pv_q  <= 1'b0;
      ps_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      v1_q  <= issue_i.valid;
      s1_q  <= issue_i.sub;
      pv_q  <= v1_q;
      ps_q  <= s1_q;
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      prod_q <= prod_d;
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = v1_q | pv_q;

endmodule

// ===== rtl/cid_seq.sv =====
module cid_seq import cid_pkg::*; #(
  parameter int MAX_SIZE = MAX_SIZE_DEF,
  localparam int CELLS   = MAX_SIZE * MAX_SIZE,
  localparam int IW      = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1,
  localparam int LW      = $clog2(MAX_SIZE + 1),
  localparam int AWM     = (CELLS > 1) ? $clog2(CELLS) : 1,
  localparam int AWP     = $clog2(2 * CELLS)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [IW-1:0]  nm1_i,
  input  logic [LW-1:0]  n_i,
  input  logic           busy_i,
  input  logic           out_free_i,
  output cid_issue_t     issue_o,
  output logic [AWP-1:0] p_raddr_o,
  output logic [AWM-1:0] m_raddr_o,
  output logic           p_we_o,
  output logic [AWP-1:0] p_waddr_o,
  output cid_wsel_e      p_wsel_o,
  output logic           out_load_o,
  output logic           idle_o
);

  cid_state_e    state_q, state_d;
  logic [IW-1:0] h_q, h_d, v_q, v_d, k_q, k_d, m_q, m_d;
  logic [LW-1:0] l_q, l_d;
  logic          sub_q, sub_d;

  logic          cell_last, last_term, below_diag, cur, prev, close_layer;

  function automatic logic [AWP-1:0] pa(input logic layer, input logic [IW-1:0] r,
                                        input logic [IW-1:0] c);
    pa = AWP'(layer) * AWP'(CELLS) + AWP'(r) * AWP'(MAX_SIZE) + AWP'(c);
  endfunction

  function automatic logic [AWM-1:0] ma(input logic [IW-1:0] r, input logic [IW-1:0] c);
    ma = AWM'(r) * AWM'(MAX_SIZE) + AWM'(c);
  endfunction

  assign cell_last   = (h_q == nm1_i) && (v_q == nm1_i);
  assign below_diag  = v_q < h_q;
  assign last_term   = sub_q ? ((k_q == nm1_i) && (m_q == nm1_i))
                             : ((k_q == nm1_i) && (v_q != h_q));
  assign cur         = l_q[0];
  assign prev        = ~l_q[0];
  assign close_layer = n_i[0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_INIT;
      end
      ST_INIT: begin
        if (cell_last) state_d = (nm1_i == '0) ? ST_CLOSE : ST_CELL;
      end
      ST_CELL: begin
        if (below_diag) begin
          if (cell_last && (l_q == n_i)) state_d = ST_CLOSE;
        end else if (last_term) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!busy_i) state_d = (cell_last && (l_q == n_i)) ? ST_CLOSE : ST_CELL;
      end
      ST_CLOSE: begin
        if (cell_last) state_d = ST_CDRAIN;
      end
      ST_CDRAIN: begin
        if (!busy_i && out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // counters
  always_comb begin
    logic step;
    step  = 1'b0;
    h_d   = h_q;
    v_d   = v_q;
    k_d   = k_q;
    m_d   = m_q;
    l_d   = l_q;
    sub_d = sub_q;
    unique case (state_q)
      ST_IDLE: begin
        h_d   = '0;
        v_d   = '0;
        k_d   = '0;
        m_d   = '0;
        sub_d = 1'b0;
      end
      ST_INIT: begin
        step = 1'b1;
        l_d  = LW'(2);
      end
      ST_CELL: begin
        if (below_diag) begin
          step = 1'b1;
          if (cell_last) l_d = l_q + LW'(1);
        end else if (!sub_q) begin
          if (k_q == nm1_i) begin
            if (v_q == h_q) begin
              sub_d = 1'b1;
              k_d   = h_q;
              m_d   = '0;
            end else begin
              k_d = '0;
            end
          end else begin
            k_d = k_q + IW'(1);
          end
        end else begin
          if (m_q == nm1_i) begin
            m_d = '0;
            if (k_q == nm1_i) begin
              k_d   = '0;
              sub_d = 1'b0;
            end else begin
              k_d = k_q + IW'(1);
            end
          end else begin
            m_d = m_q + IW'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (!busy_i) begin
          step = 1'b1;
          if (cell_last) l_d = l_q + LW'(1);
        end
      end
      ST_CLOSE: begin
        step = 1'b1;
      end
      ST_CDRAIN: begin
      end
      default: begin
      end
    endcase
    // advance along the row, then to the next head
    if (step) begin
      if (v_q == nm1_i) begin
        v_d = '0;
        h_d = (h_q == nm1_i) ? '0 : h_q + IW'(1);
      end else begin
        v_d = v_q + IW'(1);
      end
    end
  end

  // outputs
  always_comb begin
    issue_o    = '0;
    p_raddr_o  = '0;
    m_raddr_o  = '0;
    p_we_o     = 1'b0;
    p_waddr_o  = '0;
    p_wsel_o   = WS_ZERO;
    out_load_o = 1'b0;
    idle_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        idle_o = 1'b1;
      end
      ST_INIT: begin
        p_we_o    = 1'b1;
        p_waddr_o = pa(1'b1, h_q, v_q);
        p_wsel_o  = (h_q == v_q) ? WS_START : WS_ZERO;
      end
      ST_CELL: begin
        if (below_diag) begin
          p_we_o    = 1'b1;
          p_waddr_o = pa(cur, h_q, v_q);
        end else begin
          issue_o.valid = 1'b1;
          issue_o.sub   = sub_q;
          p_raddr_o     = sub_q ? pa(prev, k_q, m_q) : pa(prev, h_q, k_q);
          m_raddr_o     = sub_q ? ma(m_q, k_q) : ma(k_q, v_q);
        end
      end
      ST_DRAIN: begin
        if (!busy_i) begin
          p_we_o      = 1'b1;
          p_waddr_o   = pa(cur, h_q, v_q);
          p_wsel_o    = WS_ACC;
          issue_o.clr = 1'b1;
        end
      end
      ST_CLOSE: begin
        issue_o.valid = 1'b1;
        p_raddr_o     = pa(close_layer, h_q, v_q);
        m_raddr_o     = ma(v_q, h_q);
      end
      ST_CDRAIN: begin
        if (!busy_i && out_free_i) begin
          out_load_o  = 1'b1;
          issue_o.clr = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      h_q     <= '0;
      v_q     <= '0;
      k_q     <= '0;
      m_q     <= '0;
      l_q     <= '0;
      sub_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      h_q     <= h_d;
      v_q     <= v_d;
      k_q     <= k_d;
      m_q     <= m_d;
      l_q     <= l_d;
      sub_q   <= sub_d;
    end
  end

  a_write_after_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_we_o |-> !busy_i) else $error("table written while products still in flight");

  a_clear_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_o.clr |-> !busy_i) else $error("accumulator cleared with products in flight");

  a_term_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CELL) |-> ((k_q <= nm1_i) && (m_q <= nm1_i) && (h_q <= nm1_i)))
    else $error("term index beyond matrix size");

endmodule

// ===== rtl/clow_integer_determinant.sv =====
// Channel     | Dir | Beat contents
// s_axis      | in  | tdata: row, col, value; tlast: last (starts the determinant)
// m_axis      | out | tdata: determinant
// apb         | in  | register 0 at byte 0: matrix_size (4 bits)
//
// Elements load at one beat per cycle while the sequencer is idle.
// The beat with tlast starts the run; s_axis_tready_o stays low until it ends.
// A run issues one product term per cycle through the shared multiply-accumulate
// unit, pausing after each table entry that holds a sum until its products drain.
// The result waits in an output register; m_axis stalls delay only the next run.
// Reset clears control state and sets matrix_size to 8; the stores need no clearing.
module clow_integer_determinant import cid_pkg::*; #(
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,  // row[2:0], col[5:3], value[37:6], zero
  input  logic                 s_axis_tlast_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [DATA_W-1:0]    m_axis_tdata_o,  // determinant[31:0]
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic [PADDR_W-1:0]   paddr_i,
  input  logic [DATA_W-1:0]    pwdata_i,
  output logic [DATA_W-1:0]    prdata_o,
  output logic                 pready_o
);

  localparam int CELLS = MAX_SIZE * MAX_SIZE;
  localparam int IW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int LW    = $clog2(MAX_SIZE + 1);
  localparam int AWM   = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int AWP   = $clog2(2 * CELLS);

  logic [SIZE_W-1:0] size_q, size_d;
  logic              cfg_wr;
  logic [LW-1:0]     n_c;
  logic [IW-1:0]     nm1;

  logic [IDX_W-1:0]  in_row, in_col;
  logic [DATA_W-1:0] in_value;
  logic              in_acc, m_we;
  logic [AWM-1:0]    m_waddr, m_raddr;
  logic [DATA_W-1:0] m_rdata;

  cid_issue_t        issue;
  logic [AWP-1:0]    p_raddr, p_waddr;
  logic              p_we;
  cid_wsel_e         p_wsel;
  logic [DATA_W-1:0] p_wdata, p_rdata;

  logic [DATA_W-1:0] acc;
  logic              busy, out_load, out_free, idle;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_data_q;

  // configuration
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i & penable_i & pwrite_i;

  always_comb begin
    size_d = size_q;
    if (cfg_wr && (paddr_i[2:2] == REG_MATRIX_SIZE)) size_d = pwdata_i[SIZE_W-1:0];
  end

  always_comb begin
    prdata_o = '0;
    if (paddr_i[2:2] == REG_MATRIX_SIZE) prdata_o = DATA_W'(size_q);
  end

  // clamp n into 1..MAX_SIZE
  always_comb begin
    if (size_q == '0) begin
      n_c = LW'(1);
    end else if (32'(size_q) > MAX_SIZE) begin
      n_c = LW'(MAX_SIZE);
    end else begin
      n_c = LW'(size_q);
    end
  end
  assign nm1 = IW'(n_c - LW'(1));

  // element load
  assign in_row   = s_axis_tdata_i[2:0];
  assign in_col   = s_axis_tdata_i[5:3];
  assign in_value = s_axis_tdata_i[37:6];

  assign s_axis_tready_o = idle;
  assign in_acc  = s_axis_tvalid_i & s_axis_tready_o;
  assign m_we    = in_acc && (32'(in_row) < MAX_SIZE) && (32'(in_col) < MAX_SIZE);
  assign m_waddr = AWM'(in_row) * AWM'(MAX_SIZE) + AWM'(in_col);

  cid_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_matrix (
    .clk_i  (clk_i),
    .we_i   (m_we),
    .waddr_i(m_waddr),
    .wdata_i(in_value),
    .raddr_i(m_raddr),
    .rdata_o(m_rdata)
  );

  always_comb begin
    unique case (p_wsel)
      WS_ZERO:  p_wdata = '0;
      WS_START: p_wdata = n_c[0] ? DATA_W'(1) : '1;
      WS_ACC:   p_wdata = acc;
      default:  p_wdata = '0;
    endcase
  end

  cid_ram #(.WIDTH(DATA_W), .DEPTH(2 * CELLS)) u_table (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(p_waddr),
    .wdata_i(p_wdata),
    .raddr_i(p_raddr),
    .rdata_o(p_rdata)
  );

  cid_seq #(.MAX_SIZE(MAX_SIZE)) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (in_acc & s_axis_tlast_i),
    .nm1_i     (nm1),
    .n_i       (n_c),
    .busy_i    (busy),
    .out_free_i(out_free),
    .issue_o   (issue),
    .p_raddr_o (p_raddr),
    .m_raddr_o (m_raddr),
    .p_we_o    (p_we),
    .p_waddr_o (p_waddr),
    .p_wsel_o  (p_wsel),
    .out_load_o(out_load),
    .idle_o    (idle)
  );

  cid_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .issue_i(issue),
    .a_i    (p_rdata),
    .b_i    (m_rdata),
    .acc_o  (acc),
    .busy_o (busy)
  );

  // result register
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= SIZE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      size_q      <= size_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= acc;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready_i))
    else $error("pending determinant overwritten");

endmodule

// ===== tb/tb_clow_integer_determinant.sv =====
`timescale 1ns / 100ps

module tb_clow_integer_determinant;
  import cid_pkg::*;

  localparam int N_ITEMS   = 1200;
  localparam int LONG_HOLD = 2000;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  row;
  } elem_beat_t;

  class det_scoreboard;
    logic [DATA_W-1:0] mat [MAX_SIZE_DEF][MAX_SIZE_DEF];
    logic [SIZE_W-1:0] size_reg;
    logic [DATA_W-1:0] expected_dets [$];
    int                errors;

    function new();
      foreach (mat[r, c]) mat[r][c] = '0;
      size_reg = SIZE_RESET;
      errors   = 0;
    endfunction

    function void set_size(logic [SIZE_W-1:0] sz);
      size_reg = sz;
    endfunction

    // Clow-sequence table: layer by parity of clow length, indexed by head and current vertex
    function logic [DATA_W-1:0] clow_determinant();
      logic [DATA_W-1:0] tbl [2][MAX_SIZE_DEF][MAX_SIZE_DEF];
      logic [DATA_W-1:0] acc;
      logic [DATA_W-1:0] det;
      logic [DATA_W-1:0] seed;
      int n;
      int cur;
      int prv;
      n = int'(size_reg);
      if (n < 1) n = 1;
      if (n > MAX_SIZE_DEF) n = MAX_SIZE_DEF;
      seed = (n % 2 == 0) ? '1 : 32'd1;
      for (int h = 0; h < n; h++)
        for (int v = 0; v < n; v++)
          tbl[1][h][v] = (h == v) ? seed : '0;
      for (int len = 2; len <= n; len++) begin
        cur = len % 2;
        prv = 1 - cur;
        for (int h = 0; h < n; h++) begin
          for (int v = 0; v < n; v++) begin
            acc = '0;
            if (v >= h) begin
              for (int k = 0; k < n; k++) acc += tbl[prv][h][k] * mat[k][v];
              // close clows headed at h or later
              if (v == h) begin
                for (int k = h; k < n; k++)
                  for (int m = 0; m < n; m++)
                    acc -= tbl[prv][k][m] * mat[m][k];
              end
            end
            tbl[cur][h][v] = acc;
          end
        end
      end
      det = '0;
      for (int h = 0; h < n; h++)
        for (int v = 0; v < n; v++)
          det += tbl[n % 2][h][v] * mat[v][h];
      return det;
    endfunction

    function void note_element(elem_beat_t b, bit is_last);
      mat[b.row][b.col] = b.value;
      if (is_last) expected_dets.push_back(clow_determinant());
    endfunction

    function void check_result(logic [DATA_W-1:0] got);
      logic [DATA_W-1:0] want;
      if (expected_dets.size() == 0) begin
        errors++;
        $display("%0t: unexpected determinant beat, expected none actual %h", $time, got);
      end else begin
        want = expected_dets.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: determinant mismatch, expected %h actual %h", $time, want, got);
        end
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 s_axis_tvalid_i;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_axis_tdata_i;  // row[2:0], col[5:3], value[37:6], zero
  logic                 s_axis_tlast_i;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i;
  logic [DATA_W-1:0]    m_axis_tdata_o;  // determinant[31:0]
  logic                 psel_i;
  logic                 penable_i;
  logic                 pwrite_i;
  logic [PADDR_W-1:0]   paddr_i;
  logic [DATA_W-1:0]    pwdata_i;
  logic [DATA_W-1:0]    prdata_o;
  logic                 pready_o;

  det_scoreboard sb;
  bit            written [MAX_SIZE_DEF*MAX_SIZE_DEF];
  bit            tx_eager;
  bit            rx_eager;
  bit            hold_req;
  int            n_sent;

  clow_integer_determinant u_dut (.*);

  always #2 clk_i = ~clk_i;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return DATA_W'($signed($urandom_range(0, 8)) - 4);
      4:          return 32'h8000_0000;
      5:          return 32'h7FFF_FFFF;
      6:          return '1;
      default:    return $urandom;
    endcase
  endfunction

  task automatic send_elem(input int r, input int c, input logic [DATA_W-1:0] v,
                           input bit is_last);
    elem_beat_t b;
    int gap;
    gap     = tx_eager ? 0 : rand_gap();
    b.row   = IDX_W'(r);
    b.col   = IDX_W'(c);
    b.value = v;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tdata_i  = S_TDATA_W'(b);
    s_axis_tlast_i  = is_last;
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_element(b, is_last);
    written[r * MAX_SIZE_DEF + c] = 1'b1;
    n_sent++;
  endtask

  // Drop valid and hold until every determinant is out and the sequencer is quiet
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
    s_axis_tlast_i  = 1'b0;
    while (sb.expected_dets.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] sz);
    drain();
    psel_i    = 1'b1;
    penable_i = 1'b0;
    pwrite_i  = 1'b1;
    paddr_i   = {REG_MATRIX_SIZE, 2'b00};
    pwdata_i  = DATA_W'(sz);
    @(negedge clk_i);
    penable_i = 1'b1;
    do @(posedge clk_i); while (!pready_o);
    sb.set_size(sz);
    @(negedge clk_i);
    psel_i    = 1'b0;
    penable_i = 1'b0;
    pwrite_i  = 1'b0;
  endtask

  // Full frames rewrite the whole n by n matrix; short ones fill only the gaps.
  // Extras land anywhere in the store, inside or outside the matrix in use.
  task automatic send_frame(input int n, input bit full, input int extras);
    logic [5:0] pos_q [$];
    logic [5:0] tmp;
    int j;
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++)
        if (full || !written[r * MAX_SIZE_DEF + c]) pos_q.push_back(6'(r * 8 + c));
    repeat (extras) pos_q.push_back(6'($urandom_range(0, 63)));
    if (pos_q.size() == 0) pos_q.push_back(6'($urandom_range(0, 63)));
    for (int i = pos_q.size() - 1; i > 0; i--) begin
      j        = $urandom_range(0, i);
      tmp      = pos_q[i];
      pos_q[i] = pos_q[j];
      pos_q[j] = tmp;
    end
    foreach (pos_q[i])
      send_elem(pos_q[i][5:3], pos_q[i][2:0], rand_value(), i == pos_q.size() - 1);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) sb.check_result(m_axis_tdata_o);
  end

  initial begin : rx_side
    int stall_cnt;
    stall_cnt       = 0;
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_cnt > 0) begin
        stall_cnt--;
        m_axis_tready_i = 1'b0;
      end else if (hold_req) begin
        hold_req        = 1'b0;
        stall_cnt       = LONG_HOLD;
        m_axis_tready_i = 1'b0;
      end else if (rx_eager || $urandom_range(0, 3) != 0) begin
        m_axis_tready_i = 1'b1;
      end else begin
        m_axis_tready_i = 1'b0;
        stall_cnt       = rand_gap();
      end
    end
  end

  initial begin
    #(150_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    logic [SIZE_W-1:0] sz;
    int eff;
    int frames;
    sb              = new();
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tlast_i  = 1'b0;
    psel_i          = 1'b0;
    penable_i       = 1'b0;
    pwrite_i        = 1'b0;
    paddr_i         = '0;
    pwdata_i        = '0;
    tx_eager        = 1'b0;
    rx_eager        = 1'b0;
    hold_req        = 1'b0;
    n_sent          = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: value extremes, smallest sizes, size codes out of range
    write_size(4'd1);
    send_elem(0, 0, 32'h7FFF_FFFF, 1'b1);
    send_elem(0, 0, 32'h8000_0000, 1'b1);
    send_elem(7, 7, 32'hFFFF_FFFF, 1'b0);
    send_elem(7, 0, 32'h0000_0000, 1'b0);
    send_elem(0, 7, 32'h8000_0000, 1'b0);
    write_size(4'd0);
    send_elem(0, 0, 32'hFFFF_FFFF, 1'b1);
    write_size(4'd2);
    send_elem(0, 1, 32'h7FFF_FFFF, 1'b0);
    send_elem(1, 0, 32'h8000_0000, 1'b0);
    send_elem(1, 1, 32'd2, 1'b0);
    // last mark on an element outside the matrix in use
    send_elem(7, 7, 32'd5, 1'b1);
    write_size(4'd3);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        send_elem(r, c, 32'(r * 3 + c + 1), r == 2 && c == 2);

    // stall the result side while single-element runs pile up behind it
    write_size(4'd1);
    tx_eager = 1'b1;
    hold_req = 1'b1;
    repeat (8) send_elem(0, 0, rand_value(), 1'b1);
    tx_eager = 1'b0;

    while (n_sent < N_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1:    sz = SIZE_W'($urandom_range(5, 7));
        2:       sz = SIZE_W'($urandom_range(8, 15));
        default: sz = SIZE_W'($urandom_range(0, 4));
      endcase
      write_size(sz);
      eff      = (sz == 0) ? 1 : (sz > MAX_SIZE_DEF) ? MAX_SIZE_DEF : int'(sz);
      tx_eager = $urandom_range(0, 3) == 0;
      rx_eager = $urandom_range(0, 3) == 0;
      frames   = (eff <= 4) ? $urandom_range(3, 8) : $urandom_range(1, 2);
      repeat (frames)
        send_frame(eff, $urandom_range(0, 2) != 0, $urandom_range(0, 3));
    end
    rx_eager = 1'b0;

    drain();
    repeat (50) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
